// ===== hw/rtl/cbc_pkg.sv =====
// ----------------------------------------------------------------------------
// cbc_pkg
// Shared types and constants of the C source bracket checker.
// ----------------------------------------------------------------------------
package cbc_pkg;

  localparam int unsigned DEPTH_BITS_DEF    = 16;
  localparam int unsigned POSITION_BITS_DEF = 16;
  localparam int unsigned REPORT_BITS       = 16;
  localparam int unsigned MAX_REPORTS       = 3;

  // Characters that steer the scanner.
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_DQUOTE  = 8'h22;
  localparam logic [7:0] CH_SQUOTE  = 8'h27;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_LSQUARE = 8'h5B;
  localparam logic [7:0] CH_RSQUARE = 8'h5D;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_LCURLY  = 8'h7B;
  localparam logic [7:0] CH_RCURLY  = 8'h7D;
  localparam logic [7:0] CH_SEMI    = 8'h3B;

  typedef enum logic [1:0] {
    MODE_CODE,
    MODE_LINE,
    MODE_BLOCK
  } cbc_mode_e;

  typedef enum logic [2:0] {
    ERR_MISS_SQUARE,
    ERR_MISS_PAREN,
    ERR_MISS_CURLY,
    ERR_MISS_COMMENT,
    ERR_UNM_SQUARE,
    ERR_UNM_PAREN,
    ERR_UNM_CURLY
  } cbc_err_e;

  typedef struct packed {
    cbc_mode_e mode;
    logic      slash_pending;
    logic      star_pending;
    logic      in_quote;
    logic      prev_backslash;
  } cbc_flags_t;

  localparam cbc_flags_t FLAGS_RESET = '{
    mode:           MODE_CODE,
    slash_pending:  1'b0,
    star_pending:   1'b0,
    in_quote:       1'b0,
    prev_backslash: 1'b0
  };

  typedef struct packed {
    cbc_err_e                 kind;
    logic [REPORT_BITS-1:0]   line;
    logic [REPORT_BITS-1:0]   col;
    logic                     last;
  } cbc_res_t;

endpackage

// ===== hw/rtl/cbc_step.sv =====
// ----------------------------------------------------------------------------
// cbc_step
// Next-state and report logic for one source byte.
// ----------------------------------------------------------------------------
module cbc_step #(
  parameter int unsigned DepthBits = cbc_pkg::DEPTH_BITS_DEF,
  parameter int unsigned PosBits   = cbc_pkg::POSITION_BITS_DEF
) (
  input  logic [7:0]                      ch_i,
  input  logic                            eot_i,
  input  cbc_pkg::cbc_flags_t             flags_i,
  input  logic [DepthBits-1:0]            square_i,
  input  logic [DepthBits-1:0]            paren_i,
  input  logic [DepthBits-1:0]            curly_i,
  input  logic [PosBits-1:0]              line_i,
  input  logic [PosBits-1:0]              col_i,
  output cbc_pkg::cbc_flags_t             flags_o,
  output logic [DepthBits-1:0]            square_o,
  output logic [DepthBits-1:0]            paren_o,
  output logic [DepthBits-1:0]            curly_o,
  output logic [PosBits-1:0]              line_o,
  output logic [PosBits-1:0]              col_o,
  output logic [1:0]                      res_cnt_o,
  output cbc_pkg::cbc_err_e               res_kind_o [cbc_pkg::MAX_REPORTS],
  output logic [cbc_pkg::REPORT_BITS-1:0] rep_line_o,
  output logic [cbc_pkg::REPORT_BITS-1:0] rep_col_o
);

  cbc_pkg::cbc_flags_t  fl;
  logic [DepthBits-1:0] sq, pa, cu;
  logic [PosBits-1:0]   ln, cl;
  logic [1:0]           n;
  logic                 go_code;
  logic                 adv;
  logic [31:0]          ln_ext, cl_ext;

  always_comb begin
    fl          = flags_i;
    sq          = square_i;
    pa          = paren_i;
    cu          = curly_i;
    n           = 2'd0;
    go_code     = 1'b0;
    adv         = 1'b0;
    res_kind_o  = '{default: cbc_pkg::ERR_MISS_SQUARE};

    case (flags_i.mode)
      cbc_pkg::MODE_LINE: begin
        if (ch_i == cbc_pkg::CH_NEWLINE) begin
          fl.mode = cbc_pkg::MODE_CODE;
          go_code = 1'b1;
        end
      end
      cbc_pkg::MODE_BLOCK: begin
        if (flags_i.star_pending && ch_i == cbc_pkg::CH_SLASH) begin
          fl.star_pending = 1'b0;
          fl.mode         = cbc_pkg::MODE_CODE;
        end else begin
          adv             = 1'b1;
          fl.star_pending = (ch_i == cbc_pkg::CH_STAR);
          if (eot_i) begin
            res_kind_o[n] = cbc_pkg::ERR_MISS_COMMENT;
            n             = n + 2'd1;
          end
        end
      end
      default: begin
        fl.mode = cbc_pkg::MODE_CODE;
        go_code = 1'b1;
      end
    endcase

    if (go_code) begin
      adv = 1'b1;
      if (flags_i.slash_pending) begin
        fl.slash_pending = 1'b0;
        if (ch_i == cbc_pkg::CH_SLASH) begin
          fl.mode = cbc_pkg::MODE_LINE;
          adv     = 1'b0;
        end else if (ch_i == cbc_pkg::CH_STAR) begin
          fl.mode         = cbc_pkg::MODE_BLOCK;
          fl.star_pending = 1'b0;
          adv             = 1'b0;
          if (eot_i) begin
            res_kind_o[n] = cbc_pkg::ERR_MISS_COMMENT;
            n             = n + 2'd1;
          end
        end
      end

      if (adv) begin
        if ((ch_i == cbc_pkg::CH_DQUOTE || ch_i == cbc_pkg::CH_SQUOTE) &&
            !flags_i.prev_backslash) begin
          fl.in_quote = !flags_i.in_quote;
        end
        if (!fl.in_quote) begin
          if (ch_i == cbc_pkg::CH_SLASH && !eot_i) begin
            fl.slash_pending = 1'b1;
          end else if (ch_i == cbc_pkg::CH_LSQUARE) begin
            sq = (&square_i) ? square_i : square_i + DepthBits'(1);
          end else if (ch_i == cbc_pkg::CH_RSQUARE) begin
            if (square_i == '0) begin
              res_kind_o[n] = cbc_pkg::ERR_UNM_SQUARE;
              n             = n + 2'd1;
            end else begin
              sq = square_i - DepthBits'(1);
            end
          end else if (ch_i == cbc_pkg::CH_LPAREN) begin
            pa = (&paren_i) ? paren_i : paren_i + DepthBits'(1);
          end else if (ch_i == cbc_pkg::CH_RPAREN) begin
            if (paren_i == '0) begin
              res_kind_o[n] = cbc_pkg::ERR_UNM_PAREN;
              n             = n + 2'd1;
            end else begin
              pa = paren_i - DepthBits'(1);
            end
          end else if (ch_i == cbc_pkg::CH_LCURLY || ch_i == cbc_pkg::CH_RCURLY ||
                       ch_i == cbc_pkg::CH_SEMI || eot_i) begin
            // Statement boundary: anything still open in square or round
            // brackets is reported and dropped.
            if (square_i != '0) begin
              res_kind_o[n] = cbc_pkg::ERR_MISS_SQUARE;
              n             = n + 2'd1;
              sq            = '0;
            end
            if (paren_i != '0) begin
              res_kind_o[n] = cbc_pkg::ERR_MISS_PAREN;
              n             = n + 2'd1;
              pa            = '0;
            end
            if (eot_i) begin
              if (curly_i != '0) begin
                res_kind_o[n] = cbc_pkg::ERR_MISS_CURLY;
                n             = n + 2'd1;
                cu            = '0;
              end
            end else if (ch_i == cbc_pkg::CH_LCURLY) begin
              cu = (&curly_i) ? curly_i : curly_i + DepthBits'(1);
            end else if (ch_i == cbc_pkg::CH_RCURLY) begin
              if (curly_i == '0) begin
                res_kind_o[n] = cbc_pkg::ERR_UNM_CURLY;
                n             = n + 2'd1;
              end else begin
                cu = curly_i - DepthBits'(1);
              end
            end
          end
        end
      end
    end

    ln = line_i;
    cl = col_i;
    if (adv) begin
      if (ch_i == cbc_pkg::CH_NEWLINE) begin
        cl = '0;
        ln = (&line_i) ? line_i : line_i + PosBits'(1);
      end else begin
        cl = (&col_i) ? col_i : col_i + PosBits'(1);
      end
    end

    fl.prev_backslash = (ch_i == cbc_pkg::CH_BSLASH);
    res_cnt_o         = n;
  end

  // Reports carry the position after this byte has been counted.
  assign ln_ext     = 32'(ln);
  assign cl_ext     = 32'(cl);
  assign rep_line_o = (ln_ext > 32'h0000_FFFF) ? 16'hFFFF : ln_ext[15:0];
  assign rep_col_o  = (cl_ext > 32'h0000_FFFF) ? 16'hFFFF : cl_ext[15:0];

  // The last byte of a text returns every piece of state to its reset value.
  assign flags_o  = eot_i ? cbc_pkg::FLAGS_RESET : fl;
  assign square_o = eot_i ? '0 : sq;
  assign paren_o  = eot_i ? '0 : pa;
  assign curly_o  = eot_i ? '0 : cu;
  assign line_o   = eot_i ? PosBits'(1) : ln;
  assign col_o    = eot_i ? '0 : cl;

endmodule

// ===== hw/rtl/c_source_bracket_checker_core.sv =====
// ----------------------------------------------------------------------------
// c_source_bracket_checker_core
// Bracket, quote and comment balance checker for C source text.
// ----------------------------------------------------------------------------
// One source byte is taken per input transfer, and a byte can be taken in
// every clock cycle while the input is ready. Each byte produces zero to
// three error reports in a single cycle; they go into a four-entry report
// queue and leave one per output transfer, so a byte that yields k reports
// occupies the output for k transfers. The input is ready while the queue
// holds at most one report, which lets report-free and single-report bytes
// stream at one per cycle with the output always ready. Input tlast marks
// the final byte of a text, after which all tracking state is at reset.
module c_source_bracket_checker_core #(
  parameter int unsigned DEPTH_BITS    = cbc_pkg::DEPTH_BITS_DEF,
  parameter int unsigned POSITION_BITS = cbc_pkg::POSITION_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] ch
  input  logic        s_axis_tlast,   // end_of_text
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [15:0] line_number, [31:16] column
  output logic [2:0]  m_axis_tuser,   // [2:0] error_kind
  output logic        m_axis_tlast    // last_of_run
);

  localparam int unsigned QDepth = 4;

  cbc_pkg::cbc_flags_t      flags_q, flags_d;
  logic [DEPTH_BITS-1:0]    square_q, square_d;
  logic [DEPTH_BITS-1:0]    paren_q, paren_d;
  logic [DEPTH_BITS-1:0]    curly_q, curly_d;
  logic [POSITION_BITS-1:0] line_q, line_d;
  logic [POSITION_BITS-1:0] col_q, col_d;

  logic [1:0]               res_cnt;
  cbc_pkg::cbc_err_e        res_kind [cbc_pkg::MAX_REPORTS];
  logic [15:0]              rep_line, rep_col;
  cbc_pkg::cbc_res_t        res_w [cbc_pkg::MAX_REPORTS];

  cbc_pkg::cbc_res_t        queue_q [QDepth];
  cbc_pkg::cbc_res_t        queue_d [QDepth];
  logic [1:0]               wr_ptr_q, wr_ptr_d;
  logic [1:0]               rd_ptr_q, rd_ptr_d;
  logic [2:0]               cnt_q, cnt_d;
  logic                     push, pop;

  cbc_step #(
    .DepthBits (DEPTH_BITS),
    .PosBits   (POSITION_BITS)
  ) u_step (
    .ch_i       (s_axis_tdata),
    .eot_i      (s_axis_tlast),
    .flags_i    (flags_q),
    .square_i   (square_q),
    .paren_i    (paren_q),
    .curly_i    (curly_q),
    .line_i     (line_q),
    .col_i      (col_q),
    .flags_o    (flags_d),
    .square_o   (square_d),
    .paren_o    (paren_d),
    .curly_o    (curly_d),
    .line_o     (line_d),
    .col_o      (col_d),
    .res_cnt_o  (res_cnt),
    .res_kind_o (res_kind),
    .rep_line_o (rep_line),
    .rep_col_o  (rep_col)
  );

  assign s_axis_tready = (cnt_q <= 3'd1);
  assign push          = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = (cnt_q != 3'd0);
  assign pop           = m_axis_tvalid && m_axis_tready;

  always_comb begin
    for (int j = 0; j < cbc_pkg::MAX_REPORTS; j++) begin
      res_w[j].kind = res_kind[j];
      res_w[j].line = rep_line;
      res_w[j].col  = rep_col;
      res_w[j].last = (2'(j) == res_cnt - 2'd1);
    end
  end

  // Up to three reports of one byte are written into consecutive slots.
  always_comb begin
    logic [1:0] off;
    queue_d = queue_q;
    for (int i = 0; i < QDepth; i++) begin
      off = 2'(i) - wr_ptr_q;
      if (push && off < res_cnt) begin
        queue_d[i] = res_w[off];
      end
    end
    wr_ptr_d = push ? wr_ptr_q + res_cnt : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 2'd1 : rd_ptr_q;
    cnt_d    = cnt_q + (push ? {1'b0, res_cnt} : 3'd0) - (pop ? 3'd1 : 3'd0);
  end

  always_ff @(posedge clk_i) begin
    queue_q <= queue_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q  <= cbc_pkg::FLAGS_RESET;
      square_q <= '0;
      paren_q  <= '0;
      curly_q  <= '0;
      line_q   <= POSITION_BITS'(1);
      col_q    <= '0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        flags_q  <= flags_d;
        square_q <= square_d;
        paren_q  <= paren_d;
        curly_q  <= curly_d;
        line_q   <= line_d;
        col_q    <= col_d;
      end
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  assign m_axis_tdata = {queue_q[rd_ptr_q].col, queue_q[rd_ptr_q].line};
  assign m_axis_tuser = queue_q[rd_ptr_q].kind;
  assign m_axis_tlast = queue_q[rd_ptr_q].last;

`ifndef NO_ASSERTIONS
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'(QDepth))
    else $error("report queue count out of range");

  a_text_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && s_axis_tlast |=> square_q == '0 && paren_q == '0 && curly_q == '0 &&
                              line_q == POSITION_BITS'(1) && col_q == '0)
    else $error("state not cleared after last byte");

  a_comment_report_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == cbc_pkg::ERR_MISS_COMMENT |-> m_axis_tlast)
    else $error("open comment report not last of its run");

  a_slash_in_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flags_q.slash_pending |-> flags_q.mode == cbc_pkg::MODE_CODE)
    else $error("pending slash inside a comment");

  a_idle_count_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pop && (!push || res_cnt == 2'd0) |=> cnt_q == $past(cnt_q))
    else $error("report count changed without a transfer");
`endif

endmodule

// ===== bench/c_source_bracket_checker_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c_source_bracket_checker_core_test
// Self-checking bench for the C source bracket checker. Source bytes are
// streamed in as texts. A scoreboard predicts the error reports of every
// accepted byte and compares each output transfer with the oldest one.
// ----------------------------------------------------------------------------
module c_source_bracket_checker_core_test;
  import cbc_pkg::*;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int RANDOM_ITEMS = 380;
  localparam int IDLE_PCT     = 34;

  class bracket_scoreboard;
    cbc_mode_e   mode;
    bit          slash_pend;
    bit          star_pend;
    bit          quoted;
    bit          after_bslash;
    logic [15:0] sq_depth;
    logic [15:0] rd_depth;
    logic [15:0] cu_depth;
    logic [15:0] line_no;
    logic [15:0] col_no;
    cbc_res_t    step_reports[$];
    cbc_res_t    expected[$];
    int          errors;

    function new();
      errors = 0;
      clear();
    endfunction

    function void clear();
      mode         = MODE_CODE;
      slash_pend   = 1'b0;
      star_pend    = 1'b0;
      quoted       = 1'b0;
      after_bslash = 1'b0;
      sq_depth     = '0;
      rd_depth     = '0;
      cu_depth     = '0;
      line_no      = 16'd1;
      col_no       = '0;
    endfunction

    function void report(string msg);
      $display("ERROR: %s", msg);
      errors++;
    endfunction

    function void add_report(cbc_err_e kind);
      cbc_res_t r;
      r.kind = kind;
      r.line = line_no;
      r.col  = col_no;
      r.last = 1'b0;
      step_reports.push_back(r);
    endfunction

    function logic [15:0] bump(logic [15:0] v);
      return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function logic [15:0] closed(logic [15:0] depth, cbc_err_e kind);
      if (depth == '0) begin
        add_report(kind);
        return depth;
      end
      return depth - 16'd1;
    endfunction

    function void move_position(logic [7:0] ch);
      if (ch == CH_NEWLINE) begin
        col_no  = '0;
        line_no = bump(line_no);
      end else begin
        col_no = bump(col_no);
      end
    endfunction

    function void bracket_code(logic [7:0] ch, logic eot);
      if (ch == CH_LSQUARE) begin
        sq_depth = bump(sq_depth);
      end else if (ch == CH_RSQUARE) begin
        sq_depth = closed(sq_depth, ERR_UNM_SQUARE);
      end else if (ch == CH_LPAREN) begin
        rd_depth = bump(rd_depth);
      end else if (ch == CH_RPAREN) begin
        rd_depth = closed(rd_depth, ERR_UNM_PAREN);
      end else if (ch == CH_LCURLY || ch == CH_RCURLY || ch == CH_SEMI || eot) begin
        if (sq_depth != '0) begin
          add_report(ERR_MISS_SQUARE);
          sq_depth = '0;
        end
        if (rd_depth != '0) begin
          add_report(ERR_MISS_PAREN);
          rd_depth = '0;
        end
        // At the end of the text a closing curly is not counted first.
        if (eot) begin
          if (cu_depth != '0) begin
            add_report(ERR_MISS_CURLY);
            cu_depth = '0;
          end
        end else if (ch == CH_LCURLY) begin
          cu_depth = bump(cu_depth);
        end else if (ch == CH_RCURLY) begin
          cu_depth = closed(cu_depth, ERR_UNM_CURLY);
        end
      end
    endfunction

    function void scan(logic [7:0] ch, logic eot);
      if (mode == MODE_LINE) begin
        if (ch != CH_NEWLINE) return;
        mode = MODE_CODE;
      end else if (mode == MODE_BLOCK) begin
        if (star_pend && ch == CH_SLASH) begin
          star_pend = 1'b0;
          mode      = MODE_CODE;
          return;
        end
        move_position(ch);
        star_pend = (ch == CH_STAR);
        if (eot) add_report(ERR_MISS_COMMENT);
        return;
      end
      // A held slash either opens a comment or falls through as plain code;
      // the slash itself was already counted in the column when it arrived.
      if (slash_pend) begin
        slash_pend = 1'b0;
        if (ch == CH_SLASH) begin
          mode = MODE_LINE;
          return;
        end
        if (ch == CH_STAR) begin
          mode      = MODE_BLOCK;
          star_pend = 1'b0;
          if (eot) add_report(ERR_MISS_COMMENT);
          return;
        end
      end
      move_position(ch);
      if ((ch == CH_DQUOTE || ch == CH_SQUOTE) && !after_bslash) quoted = !quoted;
      if (quoted) return;
      if (ch == CH_SLASH && !eot) begin
        slash_pend = 1'b1;
        return;
      end
      bracket_code(ch, eot);
    endfunction

    function void note_byte(logic [7:0] ch, logic eot);
      step_reports = {};
      scan(ch, eot);
      after_bslash = (ch == CH_BSLASH);
      if (step_reports.size() != 0) step_reports[step_reports.size() - 1].last = 1'b1;
      foreach (step_reports[i]) expected.push_back(step_reports[i]);
      if (eot) clear();
    endfunction

    function void check_result(cbc_res_t got);
      cbc_res_t want;
      if (expected.size() == 0) begin
        report($sformatf("unexpected report kind %0d at %0d:%0d",
                         got.kind, got.line, got.col));
        return;
      end
      want = expected.pop_front();
      if (got.kind != want.kind)
        report($sformatf("kind %0d, want %0d", got.kind, want.kind));
      if (got.line != want.line)
        report($sformatf("line %0d, want %0d", got.line, want.line));
      if (got.col != want.col)
        report($sformatf("column %0d, want %0d", got.col, want.col));
      if (got.last != want.last)
        report($sformatf("last flag %0b, want %0b", got.last, want.last));
    endfunction
  endclass

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;

  bracket_scoreboard sb = new();
  bit                no_idle = 1'b0;
  int                cycle_count = 0;
  logic [7:0]        text_q[$];

  c_source_bracket_checker_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("c_source_bracket_checker_core_test: errors");
      $finish;
    end
  end

  // Report sink: checks every output transfer and stalls at random.
  always @(posedge clk_i) begin
    cbc_res_t got;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.kind = cbc_err_e'(m_axis_tuser);
        got.line = m_axis_tdata[15:0];
        got.col  = m_axis_tdata[31:16];
        got.last = m_axis_tlast;
        sb.check_result(got);
      end
      m_axis_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  task automatic send_byte(logic [7:0] ch, logic eot);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ch;
    s_axis_tlast  <= eot;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_byte(ch, eot);
  endtask

  // Streams the staged bytes; the final one ends the text when close is set.
  task automatic send_staged(bit close);
    foreach (text_q[i]) send_byte(text_q[i], close && (i == text_q.size() - 1));
  endtask

  function automatic void stage(string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endfunction

  task automatic send_text(string s);
    text_q = {};
    stage(s);
    send_staged(1'b1);
  endtask

  function automatic void stage_fragment();
    case ($urandom_range(0, 21))
      0, 1:    stage("[");
      2:       stage("]");
      3, 4:    stage("(");
      5:       stage(")");
      6:       stage("{");
      7:       stage("}");
      8:       stage(";");
      9:       stage("\"");
      10:      stage("'");
      11:      stage("\\");
      12:      stage("/");
      13:      stage("*");
      14:      stage("\n");
      15:      stage("//");
      16:      stage("/*");
      17:      stage("*/");
      18:      text_q.push_back(8'($urandom_range(255)));
      19:      text_q.push_back(8'($urandom_range(8'h61, 8'h7A)));
      20:      stage("{ a[i] = f(x); }\n");
      default: stage("/* c */");
    endcase
  endfunction

  initial begin
    int random_items;
    bit close;
    random_items = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Three reports from one curly, unmatched closers, closer at the last byte.
    send_text("[(}])");
    // Escaped quote inside a string; final curly with an open block.
    send_text("{\"\\\"[\"}");
    // Lone slash as code, block comment, line comment, open paren at the end.
    send_text("/(/*[*///]\n;");
    // Text ends inside a block comment, a string and a line comment.
    send_text("/*");
    send_text("\"(");
    send_text("//(");
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);

    while (random_items < RANDOM_ITEMS) begin
      no_idle = (random_items >= 150 && random_items < 260);
      text_q  = {};
      repeat ($urandom_range(1, 12)) stage_fragment();
      // Now and then a text runs on into the next one.
      close = ($urandom_range(7) != 0);
      send_staged(close);
      random_items += text_q.size();
    end
    if (!close) send_byte(CH_SEMI, 1'b1);
    s_axis_tvalid <= 1'b0;
    no_idle = 1'b0;

    while (sb.expected.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("c_source_bracket_checker_core_test: clean");
    end else begin
      $display("c_source_bracket_checker_core_test: errors");
    end
    $finish;
  end

endmodule
